/* rtl/v4alu_pkg.sv */
// Shared types and constants of the four-component vector ALU.
// No dependencies; the top level, the interfaces, the lane and the merging stage refer to this package.
package v4alu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CMD_WIDTH  = 4;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_SCALE = 4'd3,
    CMD_DIV   = 4'd4,
    CMD_NORM  = 4'd5,
    CMD_DOT   = 4'd6,
    CMD_CROSS = 4'd7,
    CMD_MAG   = 4'd8
  } cmd_e;

endpackage

/* rtl/v4alu_req_if.sv */
// Request channel of the vector ALU: opcode, vectors A and B and the scalar.
// Depends on v4alu_pkg for the default data width and the opcode width.
interface v4alu_req_if #(
  parameter int DATA_WIDTH = v4alu_pkg::DATA_WIDTH
) ();
  logic                               valid;
  logic                               ready;
  logic [v4alu_pkg::CMD_WIDTH-1:0]    cmd;
  logic signed [DATA_WIDTH-1:0]       ax;
  logic signed [DATA_WIDTH-1:0]       ay;
  logic signed [DATA_WIDTH-1:0]       az;
  logic signed [DATA_WIDTH-1:0]       aw;
  logic signed [DATA_WIDTH-1:0]       bx;
  logic signed [DATA_WIDTH-1:0]       by_comp;
  logic signed [DATA_WIDTH-1:0]       bz;
  logic signed [DATA_WIDTH-1:0]       bw;
  logic signed [DATA_WIDTH-1:0]       factor;

  modport source (output valid, cmd, ax, ay, az, aw, bx, by_comp, bz, bw, factor,
                  input ready);
  modport sink   (input valid, cmd, ax, ay, az, aw, bx, by_comp, bz, bw, factor,
                  output ready);
endinterface

/* rtl/v4alu_rsp_if.sv */
// Response channel of the vector ALU: result vector, scalar and zero flag.
// Depends on v4alu_pkg for the default data width.
interface v4alu_rsp_if #(
  parameter int DATA_WIDTH = v4alu_pkg::DATA_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] rx;
  logic signed [DATA_WIDTH-1:0] ry;
  logic signed [DATA_WIDTH-1:0] rz;
  logic signed [DATA_WIDTH-1:0] rw;
  logic signed [DATA_WIDTH-1:0] scalar_out;
  logic                         zero_divide;

  modport source (output valid, rx, ry, rz, rw, scalar_out, zero_divide, input ready);
  modport sink   (input valid, rx, ry, rz, rw, scalar_out, zero_divide, output ready);
endinterface

/* rtl/vec4_arithmetic_unit.sv */
// Four-component fixed-point vector ALU, top level.
// Depends on v4alu_pkg, v4alu_req_if, v4alu_rsp_if, v4alu_lane, v4alu_merge,
// v4alu_sqrt, v4alu_div and v4alu_delay.
//
// Usage: each request on req_i carries an opcode, vectors A and B and a scalar
// in signed fixed point with FRAC_BITS fraction bits. Every request yields
// exactly one response on rsp_o, in request order. All values saturate.
// Division or normalization by zero returns a zero vector with zero_divide set.
//
// Throughput is one request per cycle unless the receiver stalls. The whole
// datapath is a single pipeline of 2*DATA_WIDTH + FRAC_BITS + 3 register
// stages: one stage of lane multipliers, one merging stage, DATA_WIDTH square
// root stages and DATA_WIDTH + FRAC_BITS divider stages, then the response
// register. Every opcode takes the same path, so latency and order are fixed.
//
// The response register decouples the sides: the pipeline advances whenever it
// is empty or the receiver takes the response. When the receiver stalls, the
// whole pipeline holds and req_i.ready drops. Reset empties the pipeline; no
// other state exists, so the block accepts requests right after reset.
module vec4_arithmetic_unit #(
  parameter int DATA_WIDTH = v4alu_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = v4alu_pkg::FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  v4alu_req_if.sink   req_i,
  v4alu_rsp_if.source rsp_o
);
  localparam int W     = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int PW    = 2 * W;
  localparam int QW    = W + F;
  localparam int LAT_V = 2 + W + QW;
  localparam int CW    = v4alu_pkg::CMD_WIDTH;
  localparam int A_W   = CW + 9 * W;
  localparam int B_W   = CW + 5 + 5 * W;

  localparam logic signed [W-1:0] DMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] DMIN = {1'b1, {(W-1){1'b0}}};
  // The constant one, saturated where the format cannot hold it.
  localparam logic signed [W-1:0] ONE_W = (F < W - 1) ? W'(64'd1 << F) : DMAX;
  localparam logic [QW-1:0] QMAX    = {{(F+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QW-1:0] QMINMAG = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};

  // Pipeline control: one global advance keeps every stage aligned.
  logic             adv;
  logic [LAT_V-1:0] vld_q;
  logic             out_vld_q;

  assign adv         = !out_vld_q || rsp_o.ready;
  assign req_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[LAT_V-2:0], req_i.valid};
      out_vld_q <= vld_q[LAT_V-1];
    end
  end

  // Operand selection in front of the lane multipliers.
  v4alu_pkg::cmd_e     cmd_in;
  logic signed [W-1:0] a_in [4];
  logic signed [W-1:0] b_in [4];
  logic signed [W-1:0] m0a [4], m0b [4], m1a [4], m1b [4];

  assign cmd_in = v4alu_pkg::cmd_e'(req_i.cmd);
  assign a_in[0] = req_i.ax;
  assign a_in[1] = req_i.ay;
  assign a_in[2] = req_i.az;
  assign a_in[3] = req_i.aw;
  assign b_in[0] = req_i.bx;
  assign b_in[1] = req_i.by_comp;
  assign b_in[2] = req_i.bz;
  assign b_in[3] = req_i.bw;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m0a[i] = a_in[i];
      m1a[i] = '0;
      m1b[i] = '0;
      case (cmd_in)
        v4alu_pkg::CMD_SCALE: m0b[i] = req_i.factor;
        v4alu_pkg::CMD_NORM,
        v4alu_pkg::CMD_MAG:   m0b[i] = a_in[i];
        default:              m0b[i] = b_in[i];
      endcase
    end
    // Cross product: each of the first three lanes forms one 2x2 determinant.
    if (cmd_in == v4alu_pkg::CMD_CROSS) begin
      m0a[0] = a_in[1]; m0b[0] = b_in[2]; m1a[0] = a_in[2]; m1b[0] = b_in[1];
      m0a[1] = a_in[2]; m0b[1] = b_in[0]; m1a[1] = a_in[0]; m1b[1] = b_in[2];
      m0a[2] = a_in[0]; m0b[2] = b_in[1]; m1a[2] = a_in[1]; m1b[2] = b_in[0];
    end
  end

  logic signed [PW-1:0] prod [4];
  logic signed [W-1:0]  res_s2 [3];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    if (i < 3) begin : g_comp
      v4alu_lane #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_lane (
        .clk_i   (clk_i),
        .en_i    (adv),
        .cmd_i   (cmd_in),
        .mul0a_i (m0a[i]),
        .mul0b_i (m0b[i]),
        .mul1a_i (m1a[i]),
        .mul1b_i (m1b[i]),
        .add_a_i (a_in[i]),
        .add_b_i (b_in[i]),
        .prod_o  (prod[i]),
        .res_o   (res_s2[i])
      );
    end else begin : g_wlane
      // The w lane only feeds the dot product and the sum of squares.
      v4alu_lane #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_lane (
        .clk_i   (clk_i),
        .en_i    (adv),
        .cmd_i   (cmd_in),
        .mul0a_i (m0a[i]),
        .mul0b_i (m0b[i]),
        .mul1a_i (m1a[i]),
        .mul1b_i (m1b[i]),
        .add_a_i (a_in[i]),
        .add_b_i (b_in[i]),
        .prod_o  (prod[i]),
        .res_o   ()
      );
    end
  end

  // Request fields that ride alongside the lanes for the first two stages.
  v4alu_pkg::cmd_e     cmd_s1_q, cmd_s2_q;
  logic signed [W-1:0] a_s1_q [4], a_s2_q [4];
  logic signed [W-1:0] f_s1_q, f_s2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_s1_q <= cmd_in;
      cmd_s2_q <= cmd_s1_q;
      a_s1_q   <= a_in;
      a_s2_q   <= a_s1_q;
      f_s1_q   <= req_i.factor;
      f_s2_q   <= f_s1_q;
    end
  end

  logic signed [W-1:0] dot_s2;
  logic [PW-1:0]       sumsq_s2;

  v4alu_merge #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_merge (
    .clk_i   (clk_i),
    .en_i    (adv),
    .prod_i  (prod),
    .dot_o   (dot_s2),
    .sumsq_o (sumsq_s2)
  );

  // Square root of the sum of squares; the rest of the item waits beside it.
  logic [W-1:0] root;

  v4alu_sqrt #(.ROOT_WIDTH(W)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (sumsq_s2),
    .root_o (root)
  );

  logic [A_W-1:0] pay_a_in, pay_a_out;

  assign pay_a_in = {cmd_s2_q, a_s2_q[0], a_s2_q[1], a_s2_q[2], a_s2_q[3], f_s2_q,
                     res_s2[0], res_s2[1], res_s2[2], dot_s2};

  v4alu_delay #(.WIDTH(A_W), .DEPTH(W)) u_dly_a (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (pay_a_in),
    .q_o   (pay_a_out)
  );

  v4alu_pkg::cmd_e     cmd_d;
  logic signed [W-1:0] a_d [4];
  logic signed [W-1:0] f_d, dot_d;
  logic signed [W-1:0] res_d [3];
  logic                is_norm, zero_d;
  logic [W-1:0]        den_d;
  logic [W-1:0]        amag [4];
  logic [3:0]          neg_d;

  assign {cmd_d, a_d[0], a_d[1], a_d[2], a_d[3], f_d,
          res_d[0], res_d[1], res_d[2], dot_d} = pay_a_out;

  // Divide magnitudes; the sign is restored after the divider, which gives
  // rounding toward zero. Normalize divides by the length, div by |factor|.
  assign is_norm = cmd_d == v4alu_pkg::CMD_NORM;
  assign den_d   = is_norm ? root : (f_d[W-1] ? (~f_d + 1'b1) : f_d);
  assign zero_d  = is_norm ? (root == '0) : (f_d == '0);

  logic [QW-1:0] quo [4];

  for (genvar i = 0; i < 4; i++) begin : g_div
    assign amag[i]  = a_d[i][W-1] ? (~a_d[i] + 1'b1) : a_d[i];
    assign neg_d[i] = a_d[i][W-1] ^ (!is_norm && f_d[W-1]);

    v4alu_div #(.NUM_WIDTH(QW), .DEN_WIDTH(W)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i ({amag[i], {F{1'b0}}}),
      .den_i (den_d),
      .quo_o (quo[i])
    );
  end

  logic [B_W-1:0] pay_b_in, pay_b_out;

  assign pay_b_in = {cmd_d, neg_d, zero_d, res_d[0], res_d[1], res_d[2], dot_d, root};

  v4alu_delay #(.WIDTH(B_W), .DEPTH(QW)) u_dly_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (pay_b_in),
    .q_o   (pay_b_out)
  );

  v4alu_pkg::cmd_e     cmd_e_s;
  logic [3:0]          neg_e;
  logic                zero_e;
  logic signed [W-1:0] res_e [3];
  logic signed [W-1:0] dot_e;
  logic [W-1:0]        root_e;
  logic signed [W-1:0] qsat [4];

  assign {cmd_e_s, neg_e, zero_e, res_e[0], res_e[1], res_e[2], dot_e, root_e} = pay_b_out;

  // Signed, saturated quotients.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!neg_e[i]) begin
        qsat[i] = (quo[i] > QMAX) ? DMAX : quo[i][W-1:0];
      end else begin
        qsat[i] = (quo[i] > QMINMAG) ? DMIN : (~quo[i][W-1:0] + 1'b1);
      end
    end
  end

  // Response selection and register.
  logic signed [W-1:0] rx_d, ry_d, rz_d, rw_d, sc_d;
  logic signed [W-1:0] rx_q, ry_q, rz_q, rw_q, sc_q;
  logic                zd_d, zd_q;

  always_comb begin
    rx_d = '0;
    ry_d = '0;
    rz_d = '0;
    rw_d = '0;
    sc_d = '0;
    zd_d = 1'b0;
    case (cmd_e_s)
      v4alu_pkg::CMD_ADD,
      v4alu_pkg::CMD_SUB,
      v4alu_pkg::CMD_MUL,
      v4alu_pkg::CMD_SCALE,
      v4alu_pkg::CMD_CROSS: begin
        rx_d = res_e[0];
        ry_d = res_e[1];
        rz_d = res_e[2];
        rw_d = ONE_W;
      end
      v4alu_pkg::CMD_DIV: begin
        if (zero_e) begin
          zd_d = 1'b1;
        end else begin
          rx_d = qsat[0];
          ry_d = qsat[1];
          rz_d = qsat[2];
          rw_d = ONE_W;
        end
      end
      v4alu_pkg::CMD_NORM: begin
        if (zero_e) begin
          zd_d = 1'b1;
        end else begin
          rx_d = qsat[0];
          ry_d = qsat[1];
          rz_d = qsat[2];
          rw_d = qsat[3];
        end
      end
      v4alu_pkg::CMD_DOT: begin
        sc_d = dot_e;
      end
      v4alu_pkg::CMD_MAG: begin
        sc_d = root_e[W-1] ? DMAX : root_e;
      end
      default: begin
        sc_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      rz_q <= rz_d;
      rw_q <= rw_d;
      sc_q <= sc_d;
      zd_q <= zd_d;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.rx          = rx_q;
  assign rsp_o.ry          = ry_q;
  assign rsp_o.rz          = rz_q;
  assign rsp_o.rw          = rw_q;
  assign rsp_o.scalar_out  = sc_q;
  assign rsp_o.zero_divide = zd_q;

  // A zero divisor or zero length returns an all-zero response.
  a_zero_div_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && zd_q |-> rx_q == '0 && ry_q == '0 && rz_q == '0 && rw_q == '0
                          && sc_q == '0)
    else $error("zero_divide response carries nonzero data");

  // Scalar and vector results never appear together.
  a_scalar_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && sc_q != '0 |-> rx_q == '0 && ry_q == '0 && rz_q == '0 && rw_q == '0)
    else $error("scalar result with nonzero vector");

  // The pipeline moves only as a whole: a stall freezes its occupancy.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved while stalled");
endmodule

/* rtl/v4alu_delay.sv */
// Enabled shift register that carries a packed payload alongside a pipeline.
// No dependencies.
module v4alu_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);
  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];
endmodule

/* rtl/v4alu_lane.sv */
// One component lane: two registered multipliers, an adder and the saturating
// result stage. Depends on v4alu_pkg for the opcode type.
module v4alu_lane #(
  parameter int DATA_WIDTH = v4alu_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = v4alu_pkg::FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  v4alu_pkg::cmd_e                cmd_i,
  input  logic signed [DATA_WIDTH-1:0]   mul0a_i,
  input  logic signed [DATA_WIDTH-1:0]   mul0b_i,
  input  logic signed [DATA_WIDTH-1:0]   mul1a_i,
  input  logic signed [DATA_WIDTH-1:0]   mul1b_i,
  input  logic signed [DATA_WIDTH-1:0]   add_a_i,
  input  logic signed [DATA_WIDTH-1:0]   add_b_i,
  output logic signed [2*DATA_WIDTH-1:0] prod_o,
  output logic signed [DATA_WIDTH-1:0]   res_o
);
  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam logic signed [PW:0] MAX_EXT = {{(PW-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW:0] MIN_EXT = {{(PW-W+2){1'b1}}, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat(input logic signed [PW:0] v);
    logic signed [W-1:0] r;
    if (v > MAX_EXT) r = MAX_EXT[W-1:0];
    else if (v < MIN_EXT) r = MIN_EXT[W-1:0];
    else r = v[W-1:0];
    return r;
  endfunction

  logic signed [PW-1:0] p0_q, p1_q;
  logic signed [W:0]    sum_d, sum_q;
  v4alu_pkg::cmd_e      cmd_q;
  logic signed [PW:0]   diff;
  logic signed [W-1:0]  res_d, res_q;

  assign sum_d = (cmd_i == v4alu_pkg::CMD_SUB)
               ? ((W+1)'(add_a_i) - (W+1)'(add_b_i))
               : ((W+1)'(add_a_i) + (W+1)'(add_b_i));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= mul0a_i * mul0b_i;
      p1_q  <= mul1a_i * mul1b_i;
      sum_q <= sum_d;
      cmd_q <= cmd_i;
      res_q <= res_d;
    end
  end

  // Dropping the low fraction bits of a two's complement value floors it.
  assign diff = (PW+1)'(p0_q) - (PW+1)'(p1_q);

  always_comb begin
    case (cmd_q)
      v4alu_pkg::CMD_ADD,
      v4alu_pkg::CMD_SUB:   res_d = sat((PW+1)'(sum_q));
      v4alu_pkg::CMD_MUL,
      v4alu_pkg::CMD_SCALE: res_d = sat((PW+1)'($signed(p0_q[PW-1:F])));
      v4alu_pkg::CMD_CROSS: res_d = sat((PW+1)'($signed(diff[PW:F])));
      default:              res_d = '0;
    endcase
  end

  assign prod_o = p0_q;
  assign res_o  = res_q;
endmodule

/* rtl/v4alu_merge.sv */
// Merging stage: sums the four lane products into the dot product and the
// saturated sum of squares. Depends on v4alu_pkg for default widths.
module v4alu_merge #(
  parameter int DATA_WIDTH = v4alu_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = v4alu_pkg::FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [2*DATA_WIDTH-1:0] prod_i [4],
  output logic signed [DATA_WIDTH-1:0]   dot_o,
  output logic [2*DATA_WIDTH-1:0]        sumsq_o
);
  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam logic signed [PW+1:0] MAX_EXT = {{(PW-W+3){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW+1:0] MIN_EXT = {{(PW-W+3){1'b1}}, {(W-1){1'b0}}};

  logic signed [PW+1:0] dsum, dhi;
  logic [PW+1:0]        ssum;
  logic signed [W-1:0]  dot_d, dot_q;
  logic [PW-1:0]        sumsq_d, sumsq_q;

  always_comb begin
    dsum = '0;
    ssum = '0;
    for (int k = 0; k < 4; k++) begin
      dsum = dsum + (PW+2)'(prod_i[k]);
      ssum = ssum + {2'b00, prod_i[k]};
    end
    dhi = (PW+2)'($signed(dsum[PW+1:F]));
    if (dhi > MAX_EXT) dot_d = MAX_EXT[W-1:0];
    else if (dhi < MIN_EXT) dot_d = MIN_EXT[W-1:0];
    else dot_d = dhi[W-1:0];
    sumsq_d = (ssum[PW+1:PW] != 2'b00) ? '1 : ssum[PW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q   <= dot_d;
      sumsq_q <= sumsq_d;
    end
  end

  assign dot_o   = dot_q;
  assign sumsq_o = sumsq_q;
endmodule

/* rtl/v4alu_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// No dependencies.
module v4alu_sqrt #(
  parameter int ROOT_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [2*ROOT_WIDTH-1:0] rad_i,
  output logic [ROOT_WIDTH-1:0]   root_o
);
  localparam int W = ROOT_WIDTH;

  logic [2*W-1:0] rad_q  [W];
  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [2*W-1:0] rad_in;
    logic [W+1:0]   rem_in;
    logic [W-1:0]   root_in;
    logic [W+3:0]   rem_sh, trial;
    logic           take;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in, rad_in[2*W-1:2*W-2]};
    assign trial  = (W+4)'({root_in, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[2*W-3:0], 2'b00};
        rem_q[k]  <= take ? (W+2)'(rem_sh - trial) : rem_sh[W+1:0];
        root_q[k] <= {root_in[W-2:0], take};
      end
    end
  end

  assign root_o = root_q[W-1];
endmodule

/* rtl/v4alu_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// No dependencies.
module v4alu_div #(
  parameter int NUM_WIDTH = 48,
  parameter int DEN_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NUM_WIDTH-1:0] num_i,
  input  logic [DEN_WIDTH-1:0] den_i,
  output logic [NUM_WIDTH-1:0] quo_o
);
  localparam int NW = NUM_WIDTH;
  localparam int DW = DEN_WIDTH;

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in, den_in;
    logic [DW:0]   rsh;
    logic          take;

    if (k == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign rsh  = {rem_in, nq_in[NW-1]};
    assign take = rsh >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]  <= {nq_in[NW-2:0], take};
        rem_q[k] <= take ? DW'(rsh - {1'b0, den_in}) : rsh[DW-1:0];
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[NW-1];
endmodule
